FILE: design/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// shared types and constants for the motor feedback decoder
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam logic [7:0]  REPLY_MARK_A = 8'h33;
    localparam logic [7:0]  REPLY_MARK_B = 8'h55;
    localparam logic [7:0]  REG_MODE     = 8'h0A;
    localparam logic [7:0]  REG_PLIM     = 8'h15;
    localparam logic [7:0]  REG_VLIM     = 8'h16;
    localparam logic [7:0]  REG_TLIM     = 8'h17;
    localparam logic [3:0]  MOTOR_MASK   = 4'hF;
    localparam logic [30:0] LIMIT_MAX    = 31'h7FFF_FFFF;
    localparam logic [23:0] DEG_RESET    = 24'd3754936;
    localparam logic [15:0] FULL_POS     = 16'hFFFF;
    localparam logic [15:0] FULL_VT      = 16'h0FFF;
    localparam logic [9:0]  BIAS_POS     = 10'd150;
    localparam logic [9:0]  BIAS_VT      = 10'd134;
    localparam logic [1:0]  CFG_ADDR_DEG = 2'd0;

    typedef enum logic [1:0] {
        FLD_POS,
        FLD_VEL,
        FLD_TOR
    } fld_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CONV,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_TRACK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [31:0] mode;
        logic [30:0] plim;
        logic [30:0] vlim;
        logic [30:0] tlim;
    } lim_word_t;

    typedef struct packed {
        logic [31:0] last_pos;
        logic [15:0] turns;
    } trk_word_t;

    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

endpackage

FILE: design/mfd_if.sv
// ----------------------------------------------------------------------------
// mfd channel interfaces
// request channels for received frames and decoded feedback
// ----------------------------------------------------------------------------
interface mfd_in_if;
    logic       valid;
    logic       ready;
    logic       bus_select;
    logic [7:0] frame_byte0;
    logic [7:0] frame_byte1;
    logic [7:0] frame_byte2;
    logic [7:0] frame_byte3;
    logic [7:0] frame_byte4;
    logic [7:0] frame_byte5;
    logic [7:0] frame_byte6;
    logic [7:0] frame_byte7;

    modport source (
        output valid, bus_select, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
               frame_byte4, frame_byte5, frame_byte6, frame_byte7,
        input  ready
    );
    modport sink (
        input  valid, bus_select, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
               frame_byte4, frame_byte5, frame_byte6, frame_byte7,
        output ready
    );
endinterface

interface mfd_out_if;
    logic               valid;
    logic               ready;
    logic               bus_out;
    logic [3:0]         motor_index;
    logic [3:0]         motor_status;
    logic signed [31:0] position_q16;
    logic signed [31:0] velocity_q16;
    logic signed [31:0] torque_q16;
    logic signed [47:0] total_position_q16;
    logic signed [15:0] turn_total;
    logic [7:0]         transistor_temp;
    logic [7:0]         coil_temp;

    modport source (
        output valid, bus_out, motor_index, motor_status, position_q16, velocity_q16,
               torque_q16, total_position_q16, turn_total, transistor_temp, coil_temp,
        input  ready
    );
    modport sink (
        input  valid, bus_out, motor_index, motor_status, position_q16, velocity_q16,
               torque_q16, total_position_q16, turn_total, transistor_temp, coil_temp,
        output ready
    );
endinterface

FILE: design/mfd_mem.sv
// ----------------------------------------------------------------------------
// mfd_mem
// simple dual port synchronous table (one write, one read port) with per-entry valid bits, reads zero until written
// ----------------------------------------------------------------------------
module mfd_mem #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] data_reg;
    logic             hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

FILE: design/mfd_lim_conv.sv
// ----------------------------------------------------------------------------
// mfd_lim_conv
// ieee single limit word to saturated q16.16, two stages
// ----------------------------------------------------------------------------
module mfd_lim_conv
    import mfd_pkg::*;
(
    input  logic        clk,
    input  logic        start,
    input  logic        is_pos,
    input  logic [31:0] bits,
    input  logic [23:0] scale,
    output logic [30:0] result
);

    logic [7:0]         e;
    logic [23:0]        mant;
    logic [23:0]        scale_eff;
    logic [47:0]        p;
    logic signed [9:0]  s;
    logic               zero_f;
    logic               sat_f;

    logic [47:0]        p_reg;
    logic signed [9:0]  s_reg;
    logic               zero_reg;
    logic               sat_reg;

    logic [79:0]        up;
    logic [9:0]         ns;
    logic [47:0]        dn;

    always_comb
    begin
        e         = bits[30:23];
        mant      = (e == 8'd0) ? {1'b0, bits[22:0]} : {1'b1, bits[22:0]};
        scale_eff = is_pos ? scale : 24'd1;
        p         = mant * scale_eff;
        s         = $signed({2'b00, (e == 8'd0) ? 8'd1 : e})
                    - $signed(is_pos ? BIAS_POS : BIAS_VT);
        zero_f    = bits[31] | ((e == 8'hFF) & (bits[22:0] != 23'd0));
        sat_f     = ~bits[31] & (e == 8'hFF) & (bits[22:0] == 23'd0);
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg    <= p;
            s_reg    <= s;
            zero_reg <= zero_f;
            sat_reg  <= sat_f;
        end
    end

    always_comb
    begin
        up = {32'd0, p_reg} << s_reg[4:0];
        ns = 10'd0 - s_reg;
        dn = p_reg >> ns[5:0];
        if (zero_reg)
        begin
            result = '0;
        end
        else if (sat_reg)
        begin
            // positive infinity saturates even with a zero scale
            result = LIMIT_MAX;
        end
        else if (p_reg == 48'd0)
        begin
            result = '0;
        end
        else if (s_reg >= 0)
        begin
            if ((s_reg >= 10'sd31) || (up[79:31] != '0))
            begin
                result = LIMIT_MAX;
            end
            else
            begin
                result = up[30:0];
            end
        end
        else if (ns >= 10'd64)
        begin
            result = '0;
        end
        else if (dn[47:31] != '0)
        begin
            result = LIMIT_MAX;
        end
        else
        begin
            result = dn[30:0];
        end
    end

endmodule

FILE: design/mfd_div.sv
// ----------------------------------------------------------------------------
// mfd_div
// divider by a constant 2^k-1 (65535 or 4095), folds the high part into the low
// ----------------------------------------------------------------------------
module mfd_div
    import mfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_req_t    req,
    output logic        busy,
    output logic [47:0] quotient
);

    logic [47:0] x_reg;
    logic [47:0] q_reg;
    logic [15:0] div_reg;
    logic        wide_reg;
    logic        busy_reg;

    logic [47:0] hi;
    logic [47:0] lo;
    logic        last;

    // x = hi*2^k + lo = hi*(2^k-1) + hi + lo, so hi goes to the quotient
    always_comb
    begin
        hi   = wide_reg ? {16'd0, x_reg[47:16]} : {12'd0, x_reg[47:12]};
        lo   = wide_reg ? {32'd0, x_reg[15:0]}  : {36'd0, x_reg[11:0]};
        last = (hi == 48'd0);
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg    <= req.dividend;
            q_reg    <= '0;
            div_reg  <= req.divisor;
            wide_reg <= (req.divisor == FULL_POS);
        end
        else if (busy_reg)
        begin
            if (last)
            begin
                // remainder below 2^k, equal to the divisor only once
                if (x_reg == {32'd0, div_reg})
                begin
                    q_reg <= q_reg + 48'd1;
                end
            end
            else
            begin
                q_reg <= q_reg + hi;
                x_reg <= lo + hi;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && last)
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

FILE: design/motor_feedback_decoder_multiturn.sv
// ----------------------------------------------------------------------------
// motor_feedback_decoder_multiturn
// decodes motor frames against a per-bus, per-motor table of limits and turns
// ----------------------------------------------------------------------------
// decode: a feedback frame runs three passes (position, velocity, torque), each of them
//   multiply, divider start, divider steps until the high part is zero, finish; then track, emit
// a mode reply writes the table in the read state, a limit reply in the conv state
// one frame at a time: a new request is taken only in idle, after the previous frame
//   finishes; a finished result waits in its own register, stalls hold emit
// reset: rst_n clears the table valid bits (all entries read as zero) and loads deg_per_rad_q16
module motor_feedback_decoder_multiturn
    import mfd_pkg::*;
#(
    parameter int MOTORS_PER_BUS = 16,
    parameter int BUS_COUNT      = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    mfd_in_if.sink      in_ch,
    mfd_out_if.source   out_ch
);

    localparam int SLOTS = BUS_COUNT * MOTORS_PER_BUS;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // sequencer and captured request
    state_t            state_reg, state_next;
    fld_t              fld_reg, fld_next;
    logic              bus_reg;
    logic [7:0]        b_reg [8];
    logic [AW-1:0]     addr_reg;
    logic [46:0]       prod_reg, prod_next;
    logic [31:0]       pos_reg, pos_next;
    logic [31:0]       vel_reg, vel_next;
    logic [31:0]       tor_reg, tor_next;
    logic [47:0]       tp_reg, tp_next;
    logic [15:0]       turn_reg, turn_next;
    logic [23:0]       deg_reg;

    // result register, parts the sequencer from the output handshake
    logic              out_valid_reg, out_valid_next;
    logic              o_bus_reg;
    logic [3:0]        o_idx_reg, o_stat_reg;
    logic [31:0]       o_pos_reg, o_vel_reg, o_tor_reg;
    logic [47:0]       o_total_reg;
    logic [15:0]       o_turn_reg;
    logic [7:0]        o_tt_reg, o_ct_reg;
    logic              emit;

    logic              accept;
    logic              in_range;
    logic [AW-1:0]     in_addr;

    // table memories
    lim_word_t         lim_rd, lim_wr;
    trk_word_t         trk_rd, trk_wr;
    logic              lim_we, trk_we;

    // arithmetic units
    logic              conv_start;
    logic              conv_is_pos;
    logic [30:0]       conv_res;
    div_req_t          div_req;
    logic              div_busy;
    logic [47:0]       div_q;

    // decode helpers
    logic              is_reply;
    logic [15:0]       code;
    logic [30:0]       lim_sel;
    logic [33:0]       diff;
    logic [30:0]       plim;
    logic [32:0]       hp;
    logic signed [32:0] pos_s, last_s;
    logic [15:0]       t_new;
    logic signed [48:0] tp_full;
    logic [47:0]       total;

    assign accept   = in_ch.valid && in_ch.ready;
    assign in_range = (32'(in_ch.bus_select) < 32'(BUS_COUNT))
                      && (32'(in_ch.frame_byte0 & {4'd0, MOTOR_MASK}) < 32'(MOTORS_PER_BUS));
    assign in_addr  = AW'(32'(in_ch.bus_select) * 32'(MOTORS_PER_BUS)
                          + 32'(in_ch.frame_byte0[3:0]));
    assign in_ch.ready = (state_reg == ST_IDLE);

    // apb register: deg_per_rad_q16 only
    assign pready = 1'b1;
    assign prdata = (paddr == CFG_ADDR_DEG) ? {8'd0, deg_reg} : 32'd0;

    mfd_mem #(.WIDTH($bits(lim_word_t)), .DEPTH(SLOTS), .AW(AW)) u_lim_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (lim_we),
        .wr_addr (addr_reg),
        .wr_data (lim_wr),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (lim_rd)
    );

    mfd_mem #(.WIDTH($bits(trk_word_t)), .DEPTH(SLOTS), .AW(AW)) u_trk_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (trk_we),
        .wr_addr (addr_reg),
        .wr_data (trk_wr),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (trk_rd)
    );

    mfd_lim_conv u_conv (
        .clk    (clk),
        .start  (conv_start),
        .is_pos (conv_is_pos),
        .bits   ({b_reg[7], b_reg[6], b_reg[5], b_reg[4]}),
        .scale  (deg_reg),
        .result (conv_res)
    );

    mfd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // field selection for the current decode pass
    always_comb
    begin
        unique case (fld_reg)
            FLD_POS:
            begin
                code    = {b_reg[1], b_reg[2]};
                lim_sel = lim_rd.plim;
            end
            FLD_VEL:
            begin
                code    = {4'd0, b_reg[3], b_reg[4][7:4]};
                lim_sel = lim_rd.vlim;
            end
            default:
            begin
                code    = {4'd0, b_reg[4][3:0], b_reg[5]};
                lim_sel = lim_rd.tlim;
            end
        endcase
    end

    always_comb
    begin
        is_reply = (b_reg[0][7:4] == 4'd0) && (b_reg[1] == 8'd0)
                   && ((b_reg[2] == REPLY_MARK_A) || (b_reg[2] == REPLY_MARK_B));
        // quotient never exceeds twice the limit, so 33 bits hold it
        diff     = {1'b0, div_q[32:0]} - {3'd0, lim_sel};

        // turn tracking against half the position limit
        plim     = lim_rd.plim;
        hp       = {3'd0, plim[30:1]};
        pos_s    = $signed({pos_reg[31], pos_reg});
        last_s   = $signed({trk_rd.last_pos[31], trk_rd.last_pos});
        t_new    = trk_rd.turns;
        if ((pos_s > $signed(hp)) && (last_s < -$signed(hp)))
        begin
            t_new = t_new - 16'd1;
        end
        if ((pos_s < -$signed(hp)) && (last_s > $signed(hp)))
        begin
            t_new = t_new + 16'd1;
        end
        tp_full  = 49'($signed(t_new)) * 49'($signed({1'b0, plim, 1'b0}));
        total    = {{16{pos_reg[31]}}, pos_reg} + tp_reg;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        fld_next       = fld_reg;
        prod_next      = prod_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        tor_next       = tor_reg;
        tp_next        = tp_reg;
        turn_next      = turn_reg;
        lim_we         = 1'b0;
        lim_wr         = lim_rd;
        trk_we         = 1'b0;
        trk_wr         = '{last_pos: pos_reg, turns: t_new};
        conv_start     = 1'b0;
        conv_is_pos    = (b_reg[3] == REG_PLIM);
        div_req        = '{start: 1'b0, dividend: {prod_reg, 1'b0},
                           divisor: (fld_reg == FLD_POS) ? FULL_POS : FULL_VT};
        emit           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // frames outside the table are dropped here
                if (accept && in_range)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (is_reply)
                begin
                    priority if (b_reg[3] == REG_MODE)
                    begin
                        lim_we      = 1'b1;
                        lim_wr.mode = {b_reg[7], b_reg[6], b_reg[5], b_reg[4]};
                        state_next  = ST_IDLE;
                    end
                    else if ((b_reg[3] == REG_PLIM) || (b_reg[3] == REG_VLIM)
                             || (b_reg[3] == REG_TLIM))
                    begin
                        conv_start = 1'b1;
                        state_next = ST_CONV;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    fld_next   = FLD_POS;
                    state_next = ST_MUL;
                end
            end
            ST_CONV:
            begin
                lim_we = 1'b1;
                priority if (b_reg[3] == REG_PLIM)
                begin
                    lim_wr.plim = conv_res;
                end
                else if (b_reg[3] == REG_VLIM)
                begin
                    lim_wr.vlim = conv_res;
                end
                else
                begin
                    lim_wr.tlim = conv_res;
                end
                state_next = ST_IDLE;
            end
            ST_MUL:
            begin
                prod_next  = 47'(code) * 47'(lim_sel);
                state_next = ST_START;
            end
            ST_START:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    unique case (fld_reg)
                        FLD_POS:
                        begin
                            pos_next   = diff[31:0];
                            fld_next   = FLD_VEL;
                            state_next = ST_MUL;
                        end
                        FLD_VEL:
                        begin
                            vel_next   = diff[31:0];
                            fld_next   = FLD_TOR;
                            state_next = ST_MUL;
                        end
                        default:
                        begin
                            tor_next   = diff[31:0];
                            state_next = ST_TRACK;
                        end
                    endcase
                end
            end
            ST_TRACK:
            begin
                trk_we     = 1'b1;
                turn_next  = t_new;
                tp_next    = tp_full[47:0];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fld_reg       <= FLD_POS;
            out_valid_reg <= 1'b0;
            deg_reg       <= DEG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            fld_reg       <= fld_next;
            out_valid_reg <= out_valid_next;
            if (psel && penable && pwrite && (paddr == CFG_ADDR_DEG))
            begin
                deg_reg <= pwdata[23:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bus_reg  <= in_ch.bus_select;
            b_reg[0] <= in_ch.frame_byte0;
            b_reg[1] <= in_ch.frame_byte1;
            b_reg[2] <= in_ch.frame_byte2;
            b_reg[3] <= in_ch.frame_byte3;
            b_reg[4] <= in_ch.frame_byte4;
            b_reg[5] <= in_ch.frame_byte5;
            b_reg[6] <= in_ch.frame_byte6;
            b_reg[7] <= in_ch.frame_byte7;
            addr_reg <= in_addr;
        end
        prod_reg <= prod_next;
        pos_reg  <= pos_next;
        vel_reg  <= vel_next;
        tor_reg  <= tor_next;
        tp_reg   <= tp_next;
        turn_reg <= turn_next;
        if (emit)
        begin
            o_bus_reg   <= bus_reg;
            o_idx_reg   <= b_reg[0][3:0];
            o_stat_reg  <= b_reg[0][7:4];
            o_pos_reg   <= pos_reg;
            o_vel_reg   <= vel_reg;
            o_tor_reg   <= tor_reg;
            o_total_reg <= total;
            o_turn_reg  <= turn_reg;
            o_tt_reg    <= b_reg[6];
            o_ct_reg    <= b_reg[7];
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.bus_out            = o_bus_reg;
    assign out_ch.motor_index        = o_idx_reg;
    assign out_ch.motor_status       = o_stat_reg;
    assign out_ch.position_q16       = $signed(o_pos_reg);
    assign out_ch.velocity_q16       = $signed(o_vel_reg);
    assign out_ch.torque_q16         = $signed(o_tor_reg);
    assign out_ch.total_position_q16 = $signed(o_total_reg);
    assign out_ch.turn_total         = $signed(o_turn_reg);
    assign out_ch.transistor_temp    = o_tt_reg;
    assign out_ch.coil_temp          = o_ct_reg;

endmodule
